>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the RTL
// Thin wrappers around concurrent assertions, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when a holds, b must hold on the same edge.
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication: when a holds, b must hold on the following edge.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/csfv_pkg.sv
// ----------------------------------------------------------------------------
// csfv_pkg
// Types, constants and the CRC-8 helper of the sliding frame validator.
// ----------------------------------------------------------------------------
`default_nettype none

package csfv_pkg;

    localparam int unsigned WinHeld   = 3;       // bytes held ahead of the check byte
    localparam logic [7:0]  CrcPoly   = 8'h31;   // x^8 + x^5 + x^4 + 1, MSB first
    localparam logic [7:0]  CrcTopBit = 8'h80;

    typedef logic [1:0] t_fill;

    // Window contents plus the CRC over the three held bytes
    typedef struct packed {
        logic [7:0] b0;     // oldest
        logic [7:0] b1;
        logic [7:0] b2;     // newest
        logic [7:0] crc;
    } t_win;

    // One byte's worth of shifting through the CRC register (zero data in).
    // The CRC is linear with a zero seed, so crc(w0,w1,w2) is
    // T^3(w0) ^ T^2(w1) ^ T(w2) with T this function.
    function automatic logic [7:0] crc8_advance(input logic [7:0] x);
        logic [7:0] c;
        c = x;
        for (int k = 0; k < 8; k++) begin
            if ((c & CrcTopBit) != 8'h00) begin
                c = {c[6:0], 1'b0} ^ CrcPoly;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/csfv_in_if.sv
// ----------------------------------------------------------------------------
// csfv_in_if
// Input channel: one received byte per item, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface csfv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/csfv_out_if.sv
// ----------------------------------------------------------------------------
// csfv_out_if
// Result channel: frame status, frame bytes and counters per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface csfv_out_if;
    logic        valid;
    logic        ready;
    logic        frame_ok;
    logic [7:0]  msg_id;
    logic [7:0]  command;
    logic [7:0]  param;
    logic [7:0]  frame_crc;
    logic        crc_fail;
    logic [31:0] bytes_seen;
    logic [31:0] frames_valid;
    logic [31:0] frames_discarded;

    modport source (
        output valid, output frame_ok, output msg_id, output command, output param,
        output frame_crc, output crc_fail, output bytes_seen, output frames_valid,
        output frames_discarded, input ready
    );
    modport sink (
        input valid, input frame_ok, input msg_id, input command, input param,
        input frame_crc, input crc_fail, input bytes_seen, input frames_valid,
        input frames_discarded, output ready
    );
endinterface

`default_nettype wire

>>> rtl/csfv_window.sv
// ----------------------------------------------------------------------------
// csfv_window
// Three-byte shift window with per-slot CRC contributions kept alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module csfv_window (
    input  wire logic          i_clk,
    input  wire logic          i_shift,
    input  wire logic [7:0]    i_byte,
    output csfv_pkg::t_win     o_win
);
    import csfv_pkg::*;

    // Bytes, oldest in slot 0
    logic [7:0] r_b0, r_b1, r_b2;
    // Contributions: r_p0 = T^3(b0), r_p1 = T^2(b1), r_p2 = T(b2)
    logic [7:0] r_p0, r_p1, r_p2;
    logic [7:0] n_p0, n_p1, n_p2;

    // each shift moves a byte one slot older, so one more T
    always_comb begin
        n_p0 = crc8_advance(r_p1);
        n_p1 = crc8_advance(r_p2);
        n_p2 = crc8_advance(i_byte);
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_b0 <= r_b1;
            r_b1 <= r_b2;
            r_b2 <= i_byte;
            r_p0 <= n_p0;
            r_p1 <= n_p1;
            r_p2 <= n_p2;
        end
    end

    assign o_win.b0  = r_b0;
    assign o_win.b1  = r_b1;
    assign o_win.b2  = r_b2;
    assign o_win.crc = r_p0 ^ r_p1 ^ r_p2;

endmodule

`default_nettype wire

>>> rtl/crc8_sliding_frame_validator.sv
// Each accepted byte's result is registered before it goes on the output.
// Throughput: one byte per cycle while no result is pending or o_out.ready is high;
// the CRC of the held window is ready from registered per-slot contributions, so the check is one compare.
// Reset (i_rst_n, synchronous, active low): window empty, all counters zero,
// no result pending. Window bytes themselves are not reset.
// ----------------------------------------------------------------------------
// crc8_sliding_frame_validator
// Gathers 4-byte frames (id, command, parameter, CRC-8 0x31) from a byte
// stream, slides by one byte on a CRC miss and keeps wrapping counters.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module crc8_sliding_frame_validator (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    csfv_in_if.sink    i_in,
    csfv_out_if.source o_out
);
    import csfv_pkg::*;

    // ---- handshake --------------------------------------------------------
    // The result register is free when empty or being drained this cycle.
    logic r_out_valid;
    logic w_accept;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    // ---- window -----------------------------------------------------------
    t_fill r_fill, n_fill;
    t_win  w_win;
    logic  w_full;
    logic  w_match;
    logic  w_shift;

    assign w_full  = (r_fill == t_fill'(WinHeld));
    assign w_match = w_full && (w_win.crc == i_in.rx_byte);
    // Filling also shifts: slots below the fill count are don't-care, so
    // after three bytes the window is in order oldest-first anyway.
    assign w_shift = w_accept && !w_match;

    csfv_window u_window (
        .i_clk  (i_clk),
        .i_shift(w_shift),
        .i_byte (i_in.rx_byte),
        .o_win  (w_win)
    );

    always_comb begin
        n_fill = r_fill;
        if (!w_full) begin
            n_fill = r_fill + t_fill'(1);
        end else if (w_match) begin
            n_fill = '0;             // frame consumed, start over
        end
        // a miss on a full window keeps it full
    end

    // ---- counters (double as the result's counter fields) ------------------
    logic [31:0] r_bytes, r_valid_cnt, r_discard_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill        <= '0;
            r_bytes       <= '0;
            r_valid_cnt   <= '0;
            r_discard_cnt <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_accept) begin
                r_fill  <= n_fill;
                r_bytes <= r_bytes + 32'd1;
                if (w_match) begin
                    r_valid_cnt <= r_valid_cnt + 32'd1;
                end
                if (w_full && !w_match) begin
                    r_discard_cnt <= r_discard_cnt + 32'd1;
                end
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---- result register ----------------------------------------------------
    logic       r_frame_ok, r_crc_fail;
    logic [7:0] r_msg_id, r_command, r_param, r_frame_crc;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_frame_ok  <= w_match;
            r_crc_fail  <= w_full && !w_match;
            // frame bytes read as zero unless a frame was validated
            r_msg_id    <= w_match ? w_win.b0     : 8'h00;
            r_command   <= w_match ? w_win.b1     : 8'h00;
            r_param     <= w_match ? w_win.b2     : 8'h00;
            r_frame_crc <= w_match ? i_in.rx_byte : 8'h00;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.frame_ok         = r_frame_ok;
    assign o_out.msg_id           = r_msg_id;
    assign o_out.command          = r_command;
    assign o_out.param            = r_param;
    assign o_out.frame_crc        = r_frame_crc;
    assign o_out.crc_fail         = r_crc_fail;
    assign o_out.bytes_seen       = r_bytes;
    assign o_out.frames_valid     = r_valid_cnt;
    assign o_out.frames_discarded = r_discard_cnt;

    // ---- checks -------------------------------------------------------------
    // a byte taken while the window fills gives neither a frame nor a miss
    `ASSERT_NEXT(a_fill_quiet, i_clk, i_rst_n, w_accept && !w_full,
                 r_out_valid && !o_out.frame_ok && !o_out.crc_fail)
    // a validated frame empties the window
    `ASSERT_NEXT(a_match_empties, i_clk, i_rst_n, w_accept && w_match,
                 r_fill == t_fill'(0) && o_out.frame_ok)
    // a miss keeps the window full and counts a discard
    `ASSERT_NEXT(a_miss_slides, i_clk, i_rst_n, w_accept && w_full && !w_match,
                 w_full && o_out.crc_fail && r_discard_cnt != $past(r_discard_cnt))

endmodule

`default_nettype wire
